// ===== rtl/preemptive_priority_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PPS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");
`else
`define PPS_ASSERT_SAME(lbl, ante, cons)
`define PPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Table sizes, field widths, codes and the task entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

	localparam int NUM_TASKS = 8;
	localparam int TIME_BITS = 16;

	localparam int IDX_W   = $clog2(NUM_TASKS);
	localparam int CNT_W   = $clog2(NUM_TASKS + 1);
	localparam int FIELD_W = 16;
	localparam int PRIO_W  = 8;
	localparam int SLOT_W  = 3;
	localparam int CODE_W  = 2;
	localparam int WIDE_W  = 33;

	typedef enum logic [CODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CODE_W-1:0] {
		KIND_ACK  = 2'd0,
		KIND_RAN  = 2'd1,
		KIND_IDLE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RUN,
		ST_TAT,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] burst;
		logic [FIELD_W-1:0] remaining;
		logic [PRIO_W-1:0]  prio;
	} task_entry_t;

endpackage

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Flow: load, clear and unused codes go from ST_IDLE to ST_OUT; a tick goes through ST_SCAN
// and ST_RUN, then also ST_TAT and ST_WAIT when the task it runs finishes, before ST_OUT.
// Throughput: one item at a time; the tick time is set by the one-entry-per-cycle
// table scan through the single read port of the task memory.
// Reset: arst_n clears the entry valid bits, busy bits, time counter and control;
// entries not valid read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table in one memory; each tick scans it, runs the most urgent ready
// task for one unit and reports completion, turnaround and waiting times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_top_macros.svh"

module preemptive_priority_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pps_pkg::CODE_W-1:0]    opcode,
	input  logic [pps_pkg::SLOT_W-1:0]    task_index,
	input  logic [pps_pkg::FIELD_W-1:0]   arrival,
	input  logic [pps_pkg::FIELD_W-1:0]   burst_len,
	input  logic [pps_pkg::PRIO_W-1:0]    prio,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pps_pkg::CODE_W-1:0]    kind,
	output logic [pps_pkg::SLOT_W-1:0]    ran_index,
	output logic                          finished,
	output logic [pps_pkg::FIELD_W-1:0]   completion_time,
	output logic [pps_pkg::FIELD_W-1:0]   wait_time,
	output logic [pps_pkg::FIELD_W-1:0]   turnaround,
	output logic [pps_pkg::FIELD_W-1:0]   tick_time,
	output logic                          all_done
);

	import pps_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	task_entry_t mem [NUM_TASKS];

	state_t state_q, state_d;
	op_t    op_q;

	logic [NUM_TASKS-1:0] valid_q;
	logic [NUM_TASKS-1:0] busy_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     scan_cnt_q;
	logic                 found_q;
	logic                 fin_q;
	logic                 out_valid_q;

	logic                 rd_pend_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	task_entry_t          rd_data_s1;
	logic                 rd_vld_s1;

	task_entry_t          best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_BITS-1:0] comp_q;
	logic [WIDE_W-1:0]    tat_q;
	logic [WIDE_W-1:0]    wt_q;

	kind_t                kind_q;
	logic [SLOT_W-1:0]    ran_index_q;
	logic                 finished_q;
	logic [FIELD_W-1:0]   completion_q;
	logic [FIELD_W-1:0]   wait_q;
	logic [FIELD_W-1:0]   turnaround_q;
	logic [FIELD_W-1:0]   tick_time_q;
	logic                 all_done_q;

	logic                 in_acc;
	logic                 out_load;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	task_entry_t          mem_wd;
	logic                 load_ok;
	logic [IDX_W-1:0]     load_idx;
	logic                 scan_rd;
	logic [IDX_W-1:0]     rd_addr;
	task_entry_t          ent;
	logic                 ready;
	logic                 take;
	logic                 run_fin;

	assign load_ok  = int'(task_index) < NUM_TASKS;
	assign load_idx = IDX_W'(task_index);
	assign scan_rd  = (state_q == ST_SCAN) && (scan_cnt_q < CNT_W'(NUM_TASKS));
	assign rd_addr  = scan_cnt_q[IDX_W-1:0];
	assign ent      = rd_vld_s1 ? rd_data_s1 : '0;
	assign ready    = (ent.remaining != '0) && (WIDE_W'(ent.arrival) <= WIDE_W'(now_q));
	assign take     = rd_pend_s1 && ready && (!found_q || (ent.prio < best_q.prio));
	assign run_fin  = found_q && (best_q.remaining == FIELD_W'(1));
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		in_acc   = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_acc  = 1'b1;
					state_d = (opcode == OP_TICK) ? ST_SCAN : ST_OUT;
					if (opcode == OP_LOAD && load_ok) begin
						mem_we = 1'b1;
						mem_wa = load_idx;
						mem_wd = '{arrival: arrival, burst: burst_len,
							remaining: burst_len, prio: prio};
					end
				end
			end
			ST_SCAN: begin
				if (rd_pend_s1 && rd_idx_s1 == IDX_W'(NUM_TASKS - 1))
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (found_q) begin
					mem_we           = 1'b1;
					mem_wa           = best_idx_q;
					mem_wd           = best_q;
					mem_wd.remaining = best_q.remaining - FIELD_W'(1);
				end
				state_d = run_fin ? ST_TAT : ST_OUT;
			end
			ST_TAT:  state_d = ST_WAIT;
			ST_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			busy_q      <= '0;
			now_q       <= '0;
			scan_cnt_q  <= '0;
			found_q     <= 1'b0;
			rd_pend_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= scan_rd;
			rd_idx_s1  <= rd_addr;
			if (in_acc) begin
				unique case (opcode)
					OP_LOAD: begin
						if (load_ok) begin
							valid_q[load_idx] <= 1'b1;
							busy_q[load_idx]  <= (burst_len != '0);
						end
					end
					OP_CLEAR: begin
						valid_q <= '0;
						busy_q  <= '0;
						now_q   <= '0;
					end
					OP_TICK: begin
						scan_cnt_q <= '0;
						found_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (scan_rd)
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			if (take)
				found_q <= 1'b1;
			if (state_q == ST_RUN && run_fin)
				busy_q[best_idx_q] <= 1'b0;
			if (out_load && op_q == OP_TICK && now_q != TIME_MAX)
				now_q <= now_q + TIME_BITS'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[rd_addr];
		if (in_acc) begin
			op_q  <= op_t'(opcode);
			fin_q <= 1'b0;
		end
		if (take) begin
			best_q     <= ent;
			best_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_RUN) begin
			fin_q  <= run_fin;
			comp_q <= (now_q == TIME_MAX) ? now_q : now_q + TIME_BITS'(1);
		end
		if (state_q == ST_TAT) begin
			tat_q <= (WIDE_W'(comp_q) > WIDE_W'(best_q.arrival))
				? WIDE_W'(comp_q) - WIDE_W'(best_q.arrival) : '0;
		end
		if (state_q == ST_WAIT) begin
			wt_q <= (tat_q > WIDE_W'(best_q.burst)) ? tat_q - WIDE_W'(best_q.burst) : '0;
		end
		if (out_load) begin
			if (op_q != OP_TICK)
				kind_q <= KIND_ACK;
			else if (found_q)
				kind_q <= KIND_RAN;
			else
				kind_q <= KIND_IDLE;
			ran_index_q  <= (op_q == OP_TICK && found_q) ? SLOT_W'(best_idx_q) : '0;
			finished_q   <= fin_q;
			completion_q <= fin_q ? FIELD_W'(comp_q) : '0;
			wait_q       <= fin_q ? FIELD_W'(wt_q) : '0;
			turnaround_q <= fin_q ? FIELD_W'(tat_q) : '0;
			tick_time_q  <= FIELD_W'(now_q);
			all_done_q   <= (busy_q == '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign ran_index       = ran_index_q;
	assign finished        = finished_q;
	assign completion_time = completion_q;
	assign wait_time       = wait_q;
	assign turnaround      = turnaround_q;
	assign tick_time       = tick_time_q;
	assign all_done        = all_done_q;

	`PPS_ASSERT_SAME(a_wait_le_tat, out_valid, wait_time <= turnaround)
	`PPS_ASSERT_SAME(a_fin_kind, out_valid && finished, kind == KIND_RAN)
	`PPS_ASSERT_NEXT(a_fin_clears, state_q == ST_RUN && run_fin, !busy_q[best_idx_q])
	`PPS_ASSERT_NEXT(a_now_mono, !(in_acc && opcode == OP_CLEAR), now_q >= $past(now_q))

endmodule

// ===== dv/preemptive_priority_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Sends load, tick, clear and unused-code items and checks every result
// against an in-bench model of the task table and time counter. Covers tie
// breaks, reloads, empty and future slots, a long output hold-off that fills
// the block, a drained sender pause and random traffic with idle bursts on
// both sides.
// ----------------------------------------------------------------------------

module preemptive_priority_scheduler_top_test;
	import pps_pkg::*;

	localparam logic [CODE_W-1:0]    OP_SPARE     = 2'd3;
	localparam logic [TIME_BITS-1:0] TIME_TOP     = '1;
	localparam int                   QUIET_LIMIT  = 4000;
	localparam int                   LONG_HOLD    = 400;
	localparam int                   DRAIN_CYCLES = 3 * (NUM_TASKS + 6);

	typedef struct packed {
		kind_t                res_kind;
		logic [SLOT_W-1:0]    slot;
		logic                 done_now;
		logic [FIELD_W-1:0]   comp;
		logic [FIELD_W-1:0]   wait_cyc;
		logic [FIELD_W-1:0]   tat;
		logic [FIELD_W-1:0]   stamp;
		logic                 idle_all;
	} sched_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CODE_W-1:0]    opcode = OP_LOAD;
	logic [SLOT_W-1:0]    task_index = '0;
	logic [FIELD_W-1:0]   arrival = '0;
	logic [FIELD_W-1:0]   burst_len = '0;
	logic [PRIO_W-1:0]    prio = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CODE_W-1:0]    kind;
	logic [SLOT_W-1:0]    ran_index;
	logic                 finished;
	logic [FIELD_W-1:0]   completion_time;
	logic [FIELD_W-1:0]   wait_time;
	logic [FIELD_W-1:0]   turnaround;
	logic [FIELD_W-1:0]   tick_time;
	logic                 all_done;

	logic [FIELD_W-1:0]   arr_tbl   [NUM_TASKS];
	logic [FIELD_W-1:0]   burst_tbl [NUM_TASKS];
	logic [FIELD_W-1:0]   left_tbl  [NUM_TASKS];
	logic [PRIO_W-1:0]    prio_tbl  [NUM_TASKS];
	logic [TIME_BITS-1:0] sched_now = '0;

	sched_result_t        sched_expect_q[$];
	int                   err_count = 0;
	int                   quiet_cycles = 0;
	bit                   tx_gaps = 1'b1;
	bit                   rx_gaps = 1'b1;
	int                   hold_order = 0;
	int                   hold_seen = 0;
	int                   hold_left = 0;
	int                   stall_left = 0;

	preemptive_priority_scheduler_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < NUM_TASKS; k++) begin
			arr_tbl[k] = '0;
			burst_tbl[k] = '0;
			left_tbl[k] = '0;
			prio_tbl[k] = '0;
		end
	end

	function automatic sched_result_t schedule_step(input logic [CODE_W-1:0] op,
			input logic [SLOT_W-1:0] slot, input logic [FIELD_W-1:0] arr,
			input logic [FIELD_W-1:0] brs, input logic [PRIO_W-1:0] pr);
		sched_result_t r;
		int pick;
		logic [TIME_BITS-1:0] comp;
		logic [TIME_BITS-1:0] tat;
		r = '0;
		pick = -1;
		r.res_kind = KIND_ACK;
		r.stamp = sched_now;
		if (op == OP_LOAD) begin
			if (slot < NUM_TASKS) begin
				arr_tbl[slot] = arr;
				burst_tbl[slot] = brs;
				left_tbl[slot] = brs;
				prio_tbl[slot] = pr;
			end
		end else if (op == OP_CLEAR) begin
			for (int k = 0; k < NUM_TASKS; k++) begin
				arr_tbl[k] = '0;
				burst_tbl[k] = '0;
				left_tbl[k] = '0;
				prio_tbl[k] = '0;
			end
			sched_now = '0;
			r.stamp = '0;
		end else if (op == OP_TICK) begin
			for (int k = 0; k < NUM_TASKS; k++) begin
				if (left_tbl[k] != 0 && arr_tbl[k] <= sched_now &&
						(pick < 0 || prio_tbl[k] < prio_tbl[pick]))
					pick = k;
			end
			if (pick < 0) begin
				r.res_kind = KIND_IDLE;
			end else begin
				r.res_kind = KIND_RAN;
				r.slot = pick[SLOT_W-1:0];
				left_tbl[pick] = left_tbl[pick] - 1'b1;
				if (left_tbl[pick] == 0) begin
					comp = (sched_now != TIME_TOP) ? sched_now + 1'b1 : TIME_TOP;
					tat = (comp > arr_tbl[pick]) ? comp - arr_tbl[pick] : '0;
					r.done_now = 1'b1;
					r.comp = comp;
					r.tat = tat;
					r.wait_cyc = (tat > burst_tbl[pick]) ? tat - burst_tbl[pick] : '0;
				end
			end
			if (sched_now != TIME_TOP)
				sched_now = sched_now + 1'b1;
		end
		r.idle_all = 1'b1;
		for (int k = 0; k < NUM_TASKS; k++) begin
			if (left_tbl[k] != 0)
				r.idle_all = 1'b0;
		end
		return r;
	endfunction

	task automatic send_item(input logic [CODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] brs,
			input logic [PRIO_W-1:0] pr);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		task_index <= slot;
		arrival <= arr;
		burst_len <= brs;
		prio <= pr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sched_expect_q.push_back(schedule_step(op, slot, arr, brs, pr));
	endtask

	task automatic send_random_item();
		logic [CODE_W-1:0] op;
		logic [SLOT_W-1:0] slot;
		logic [FIELD_W-1:0] arr;
		logic [FIELD_W-1:0] brs;
		logic [PRIO_W-1:0] pr;
		int roll;
		int unsigned near;
		roll = $urandom_range(0, 99);
		if (roll < 42)
			op = OP_LOAD;
		else if (roll < 95)
			op = OP_TICK;
		else if (roll < 98)
			op = OP_CLEAR;
		else
			op = OP_SPARE;
		slot = SLOT_W'($urandom_range(0, NUM_TASKS - 1));
		near = sched_now + $urandom_range(0, 12);
		if ($urandom_range(0, 4) == 0)
			arr = FIELD_W'($urandom_range(0, 16'hFFFF));
		else
			arr = (near > TIME_TOP) ? TIME_TOP : near[FIELD_W-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 8)
			brs = '0;
		else if (roll < 13)
			brs = FIELD_W'($urandom_range(0, 16'hFFFF));
		else
			brs = FIELD_W'($urandom_range(1, 6));
		pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3))
			: PRIO_W'($urandom_range(0, 255));
		send_item(op, slot, arr, brs, pr);
	endtask

	task automatic test_directed_ops();
		send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_SPARE, 3'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_item(OP_LOAD, 3'd7, 16'd0, 16'd1, 8'hFF);
		send_item(OP_LOAD, 3'd3, 16'd0, 16'd2, 8'd5);
		send_item(OP_LOAD, 3'd5, 16'd0, 16'd1, 8'd5);
		send_item(OP_LOAD, 3'd6, 16'd3, 16'd1, 8'd0);
		send_item(OP_LOAD, 3'd4, 16'd0, 16'd0, 8'd0);
		send_item(OP_LOAD, 3'd0, 16'hFFFF, 16'd3, 8'd0);
		repeat (3) send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_LOAD, 3'd3, 16'd1, 16'd4, 8'd1);
		repeat (3) send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_LOAD, 3'd3, 16'd2, 16'd2, 8'd1);
		repeat (3) send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_CLEAR, 3'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
	endtask

	task automatic test_output_hold();
		tx_gaps = 1'b0;
		hold_order = hold_order + 1;
		repeat (8) send_random_item();
		tx_gaps = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (6) send_random_item();
		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0)
			@(posedge clk);
		repeat (6) send_random_item();
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				tx_gaps = ($urandom_range(0, 2) != 0);
				rx_gaps = ($urandom_range(0, 2) != 0);
			end
			send_random_item();
		end
	endtask

	task automatic test_steady_stream(input int count);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (count) send_random_item();
	endtask

	always @(posedge clk) begin
		if (hold_order != hold_seen) begin
			hold_seen <= hold_order;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void check_field(input string name, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sched_expect_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d",
					$time, kind);
				err_count++;
			end else begin
				want = sched_expect_q.pop_front();
				check_field("kind", kind, want.res_kind);
				check_field("ran_index", ran_index, want.slot);
				check_field("finished", finished, want.done_now);
				check_field("completion_time", completion_time, want.comp);
				check_field("wait_time", wait_time, want.wait_cyc);
				check_field("turnaround", turnaround, want.tat);
				check_field("tick_time", tick_time, want.stamp);
				check_field("all_done", all_done, want.idle_all);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("preemptive_priority_scheduler_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_output_hold();
		test_sender_pause();
		test_random_mix(1200);
		test_steady_stream(250);
		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("preemptive_priority_scheduler_top verification clean");
		else
			$display("preemptive_priority_scheduler_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/preemptive_priority_scheduler_top.sv
dv/preemptive_priority_scheduler_top_test.sv
